@@ rtl/core/sdpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpg_pkg : shared constants for the step/direction pulse generator
// Field widths, register indices, reset values and derived divider sizes.
// ----------------------------------------------------------------------------
package sdpg_pkg;

  // Position kept internally at POS_W bits, presented on the port at OUT_POS_W
  localparam int POS_W            = 32;
  localparam int OUT_POS_W        = 32;

  // Timebase: ticks per second (one tick per microsecond)
  localparam int TICKS_PER_SECOND = 1000000;

  // Field widths
  localparam int RATE_W           = 16;
  localparam int PERIOD_W         = 20;
  localparam int SETUP_W          = 10;
  localparam int WIDTH_W          = 10;

  // Stream payload widths (packed, rounded up to whole bytes)
  localparam int IN_DATA_W        = 56;
  localparam int OUT_DATA_W       = 40;

  // Configuration port
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIR_SETUP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_WIRED  = 2'd3;

  // Register reset values
  localparam int SETUP_RESET        = 5;
  localparam int WIDTH_RESET        = 5;
  localparam int DEFAULT_RATE_RESET = 1000;

  // Step period limits; the reset period is worked out at elaboration
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam int PERIOD_RAW   = TICKS_PER_SECOND / DEFAULT_RATE_RESET;
  localparam int PERIOD_RESET = (PERIOD_RAW > (2 ** PERIOD_W) - 1) ?
                                ((2 ** PERIOD_W) - 1) : PERIOD_RAW;

  // Bit-serial divider sizing: dividend/quotient shift register width
  localparam int TICKS_W    = $clog2(TICKS_PER_SECOND + 1);
  localparam int DIV_W      = (TICKS_W > PERIOD_W) ? TICKS_W : PERIOD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // Bit-serial position pass
  localparam int PASS_CNT_W = $clog2(POS_W);

endpackage

@@ rtl/core/step_dir_pulse_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_dir_pulse_generator : stepper step/direction pulse generator
// One input transaction per microsecond tick. Holds position and goal, runs
// the setup / pulse high / pulse low / gap sequence, tracks the drive alarm.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Direction  Content
//  --------  -------------------------------  ---------  ------------------------
//  s_*       s_tvalid s_tready s_tdata s_tuser  in       one tick, optional command
//  m_*       m_tvalid m_tready m_tdata          out      line levels and status
//  cfg_*     cfg_we cfg_index cfg_data          in       register writes
//
//  A tick runs through accept, timer update, a bit-serial position pass,
//  step start and result load. A command tick with a non-zero step rate
//  also runs the one-bit-a-cycle period divider; a default rate write keeps
//  s_tready low in its write cycle and while the divider runs after it.
//  Reset (rst, synchronous) clears position, goal and phase and loads the
//  default rate and its period. A stalled m_tready holds the result register;
//  the next tick is accepted and worked on meanwhile, and waits at load.
//
module step_dir_pulse_generator
  import sdpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] target_position, [47:32] cmd_step_rate,
                                           // [48] alarm_level, [55:49] zero
  input  logic                  s_tuser,   // [0] cmd_valid
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] pulse_pos, [1] pulse_neg, [2] dir_pos,
                                           // [3] dir_neg, [35:4] position, [36] moving,
                                           // [37] fault, [38] fault_raised,
                                           // [39] fault_cleared
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_TIMER = 3'd2;
  localparam logic [2:0] ST_PASS  = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  // Step phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_LOW   = 3'd3;
  localparam logic [2:0] PH_GAP   = 3'd4;

  logic [2:0]            state;
  logic                  tick_pending;

  // Configuration
  logic [SETUP_W-1:0]    dir_hold_us;
  logic [WIDTH_W-1:0]    pulse_width_us;
  logic                  alarm_wired;

  // Motion state
  logic [POS_W-1:0]      cur;
  logic [POS_W-1:0]      goal;
  logic [PERIOD_W-1:0]   period_us;
  logic [2:0]            phase;
  logic [PERIOD_W-1:0]   phase_count;
  logic                  going_forward;
  logic                  fault_prev;

  // Per-tick alarm status
  logic                  alarm_fault;
  logic                  alarm_raise;
  logic                  alarm_clear;

  // Divider
  logic [RATE_W-1:0]     divisor;
  logic [RATE_W-1:0]     rem;
  logic [DIV_W-1:0]      dq;
  logic [DIV_W-1:0]      dq_next;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [RATE_W:0]       rem_sh;
  logic                  div_ge;
  logic [RATE_W-1:0]     rem_next;
  logic [PERIOD_W-1:0]   quot_sat;

  // Serial position pass
  logic [PASS_CNT_W-1:0] pass_cnt;
  logic                  step_inc;
  logic                  carry;
  logic                  pos_eq;
  logic                  goal_gt;
  logic                  bit_cur;
  logic                  bit_goal;
  logic                  bit_new;
  logic                  carry_next;
  logic                  last_bit;
  logic                  gt_bit;

  // Timer
  logic [PERIOD_W-1:0]   width_eff;
  logic [PERIOD_W-1:0]   cnt_dec;
  logic [2:0]            phase_next;
  logic [PERIOD_W-1:0]   count_next;
  logic                  step_inc_next;

  logic                  s_fire;
  logic                  cfg_rate_wr;
  logic [RATE_W-1:0]     cmd_rate;
  logic [RATE_W-1:0]     cfg_rate;

  // a default rate write in the idle cycle holds off the input for that cycle
  assign cfg_rate_wr = cfg_we && (cfg_index == REG_DEFAULT_RATE);
  assign s_tready    = (state == ST_IDLE) && !cfg_rate_wr;
  assign s_fire      = s_tvalid & s_tready;
  assign cmd_rate    = s_tdata[47:32];
  assign cfg_rate    = (cfg_data[RATE_W-1:0] == '0) ? RATE_W'(1) : cfg_data[RATE_W-1:0];

  // Restoring divider step: one quotient bit a cycle unless a default rate write restarts it
  assign rem_sh   = {rem, dq[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, divisor};
  assign rem_next = div_ge ? RATE_W'(rem_sh - {1'b0, divisor}) : rem_sh[RATE_W-1:0];
  assign dq_next  = {dq[DIV_W-2:0], div_ge};
  assign quot_sat = (dq_next > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX : dq_next[PERIOD_W-1:0];

  // Serial increment/decrement and compare, LSB first
  assign bit_cur    = cur[0];
  assign bit_goal   = goal[0];
  assign bit_new    = bit_cur ^ carry;
  assign carry_next = going_forward ? (bit_cur & carry) : (~bit_cur & carry);
  assign last_bit   = (pass_cnt == PASS_CNT_W'(POS_W - 1));
  // sign bit compares inverted for a signed result
  assign gt_bit     = last_bit ? (~bit_goal & bit_new) : (bit_goal & ~bit_new);

  // Phase timer for one tick
  assign width_eff = (pulse_width_us == '0) ? PERIOD_W'(1) : PERIOD_W'(pulse_width_us);
  assign cnt_dec   = (phase_count != '0) ? phase_count - 1'b1 : phase_count;

  always_comb begin
    phase_next    = phase;
    count_next    = phase_count;
    step_inc_next = 1'b0;
    if (phase != PH_IDLE) begin
      count_next = cnt_dec;
      if (cnt_dec == '0) begin
        case (phase)
          PH_SETUP: begin
            phase_next = PH_HIGH;
            count_next = width_eff;
          end
          PH_HIGH: begin
            phase_next = PH_LOW;
            count_next = width_eff;
          end
          PH_LOW: begin
            step_inc_next = 1'b1;
            if (period_us == '0) begin
              phase_next = PH_IDLE;
              count_next = '0;
            end else begin
              phase_next = PH_GAP;
              count_next = period_us;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            count_next = '0;
          end
        endcase
      end
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_pending   <= 1'b0;
      dir_hold_us    <= SETUP_W'(SETUP_RESET);
      pulse_width_us <= WIDTH_W'(WIDTH_RESET);
      alarm_wired    <= 1'b0;
      divisor        <= RATE_W'(DEFAULT_RATE_RESET);
      period_us      <= PERIOD_W'(PERIOD_RESET);
      cur            <= '0;
      goal           <= '0;
      phase          <= PH_IDLE;
      phase_count    <= '0;
      going_forward  <= 1'b0;
      fault_prev     <= 1'b0;
      alarm_fault    <= 1'b0;
      alarm_raise    <= 1'b0;
      alarm_clear    <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // result taken; a load in the same cycle keeps it valid
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      // plain register writes take effect in any state
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_SETUP:   dir_hold_us    <= cfg_data[SETUP_W-1:0];
          REG_PULSE_WIDTH: pulse_width_us <= cfg_data[WIDTH_W-1:0];
          REG_ALARM_WIRED: alarm_wired    <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (cfg_rate_wr) begin
            // a default rate write reloads the period
            divisor      <= cfg_rate;
            rem          <= '0;
            dq           <= DIV_W'(TICKS_PER_SECOND);
            div_cnt      <= DIV_CNT_W'(DIV_W - 1);
            tick_pending <= 1'b0;
            state        <= ST_DIV;
          end else if (s_fire) begin
            // alarm tracking
            if (alarm_wired) begin
              alarm_fault <= ~s_tdata[48];
              alarm_raise <= ~s_tdata[48] & ~fault_prev;
              alarm_clear <= s_tdata[48] & fault_prev;
              fault_prev  <= ~s_tdata[48];
            end else begin
              alarm_fault <= 1'b0;
              alarm_raise <= 1'b0;
              alarm_clear <= 1'b0;
            end
            // command acceptance
            if (s_tuser) begin
              goal <= POS_W'($signed(s_tdata[31:0]));
            end
            if (s_tuser && (cmd_rate != '0)) begin
              divisor      <= cmd_rate;
              rem          <= '0;
              dq           <= DIV_W'(TICKS_PER_SECOND);
              div_cnt      <= DIV_CNT_W'(DIV_W - 1);
              tick_pending <= 1'b1;
              state        <= ST_DIV;
            end else begin
              state <= ST_TIMER;
            end
          end
        end

        ST_DIV: begin
          if (cfg_rate_wr && !tick_pending) begin
            // back-to-back default rate write restarts the divider
            divisor <= cfg_rate;
            rem     <= '0;
            dq      <= DIV_W'(TICKS_PER_SECOND);
            div_cnt <= DIV_CNT_W'(DIV_W - 1);
          end else begin
            rem     <= rem_next;
            dq      <= dq_next;
            div_cnt <= div_cnt - 1'b1;
            if (div_cnt == '0) begin
              // last quotient bit: period is ready; a pending tick goes on to its timer
              period_us <= quot_sat;
              state     <= tick_pending ? ST_TIMER : ST_IDLE;
            end
          end
        end

        ST_TIMER: begin
          phase       <= phase_next;
          phase_count <= count_next;
          step_inc    <= step_inc_next;
          carry       <= step_inc_next;
          pos_eq      <= 1'b1;
          goal_gt     <= 1'b0;
          pass_cnt    <= '0;
          state       <= ST_PASS;
        end

        ST_PASS: begin
          // one bit of position and goal a cycle, both rotate back in place
          cur      <= {bit_new, cur[POS_W-1:1]};
          goal     <= {bit_goal, goal[POS_W-1:1]};
          carry    <= carry_next;
          pos_eq   <= pos_eq & (bit_new == bit_goal);
          goal_gt  <= gt_bit | (~(bit_goal ^ bit_new) & goal_gt);
          pass_cnt <= pass_cnt + 1'b1;
          if (last_bit) begin
            state <= ST_START;
          end
        end

        ST_START: begin
          // a new step starts from idle when the goal differs
          if ((phase == PH_IDLE) && !pos_eq) begin
            going_forward <= goal_gt;
            if (dir_hold_us == '0) begin
              phase       <= PH_HIGH;
              phase_count <= width_eff;
            end else begin
              phase       <= PH_SETUP;
              phase_count <= PERIOD_W'(dir_hold_us);
            end
          end
          state <= ST_EMIT;
        end

        ST_EMIT: begin
          // load the result register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {alarm_clear, alarm_raise, alarm_fault,
                         (phase != PH_IDLE),
                         OUT_POS_W'($signed(cur)),
                         ~going_forward, going_forward,
                         (phase != PH_HIGH), (phase == PH_HIGH)};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && phase != PH_IDLE) |-> (phase_count != '0))
    else $error("active phase with zero count between ticks");

  a_idle_at_goal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && phase == PH_IDLE) |-> (cur == goal))
    else $error("idle phase while position differs from goal");

  a_dir_on_start: assert property (@(posedge clk) disable iff (rst)
    (state != ST_START) |=> $stable(going_forward))
    else $error("direction changed outside step start");

  a_step_inc_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS && step_inc) |-> (phase == PH_GAP || phase == PH_IDLE))
    else $error("position step outside end of pulse");

endmodule
